### rtl/core/pswu_pkg.sv
// shared types and constants of the process sleep/wakeup scheduler
package pswu_pkg;

	localparam int CHAN_W      = 16;
	localparam int PRIO_W      = 8;
	localparam int CEIL_W      = 7;
	localparam int STAT_W      = 3;
	localparam int MODE_W      = 3;
	localparam int SLOT_W      = 4;
	localparam int COUNT_W     = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// item modes
	localparam logic [MODE_W-1:0] MODE_INSTALL    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SLEEP      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WAKE       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PICK       = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SET_LOADED = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SET_FLAGS  = 3'd5;

	// slot status codes
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd0;
	localparam logic [STAT_W-1:0] STAT_SLEEPING = 3'd1;
	localparam logic [STAT_W-1:0] STAT_WAITING  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_RUNNABLE = 3'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_CEILING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWAP_IN_CHAN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWAP_OUT_CHAN = 2'd2;

	localparam logic [CEIL_W-1:0] PRIO_CEILING_RST  = 7'd120;
	localparam logic [CHAN_W-1:0] SWAP_IN_CHAN_RST  = 16'd1;
	localparam logic [CHAN_W-1:0] SWAP_OUT_CHAN_RST = 16'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT,
		ST_WAKE_START,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [SLOT_W-1:0]        slot;
		logic [CHAN_W-1:0]        channel;
		logic signed [PRIO_W-1:0] priority_req;
		logic                     signal_pending;
		logic [STAT_W-1:0]        new_status;
		logic                     loaded_mark;
		logic                     want_swap_in;
		logic                     want_swap_out;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  chosen_slot;
		logic               chosen_valid;
		logic [COUNT_W-1:0] woken_count;
		logic               reschedule;
		logic               sleep_aborted;
	} rsp_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic                     loaded;
		logic signed [PRIO_W-1:0] prio;
		logic [CHAN_W-1:0]        channel;
	} entry_t;

endpackage

### rtl/core/pswu_table.sv
// process slot table: synchronous memory with one read port, one write port and per-entry valid bits
module pswu_table #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output pswu_pkg::entry_t   rd_entry,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  pswu_pkg::entry_t   wr_entry
);

	pswu_pkg::entry_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	pswu_pkg::entry_t rd_data_q;
	logic             rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written entries read as the all-zero reset entry
	assign rd_entry = rd_hit_q ? rd_data_q : '0;

endmodule

### rtl/core/process_sleep_wakeup_scheduler.sv
// top level of the process sleep/wakeup scheduler; one transaction in flight at a time
// install, set loaded, sleep: read, write in ST_SLOT, then ST_EMIT; set flags, unused modes,
// an aborted sleep and a slot beyond the table: straight to ST_EMIT
// wake and pick: one table pass over the SLOT_COUNT slots in ST_SCAN, then ST_EMIT
// a wake that clears the swap-out flag adds a second pass; sleep that
// clears the swap-in flag adds one or two such passes; reset clears table valid bits at once
module process_sleep_wakeup_scheduler #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  pswu_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output pswu_pkg::rsp_t                     rsp,
	input  logic                               cfg_we,
	input  logic [pswu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pswu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [pswu_pkg::COUNT_W-1:0] COUNT_MAX = '1;

	pswu_pkg::state_t state_q, state_d;
	pswu_pkg::req_t   req_q;
	pswu_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic [pswu_pkg::CEIL_W-1:0] prio_ceiling_q;
	logic [pswu_pkg::CHAN_W-1:0] swap_in_chan_q;
	logic [pswu_pkg::CHAN_W-1:0] swap_out_chan_q;
	logic                        swap_in_q;
	logic                        swap_out_q;
	logic [IDX_W-1:0]            last_q;

	logic [IDX_W-1:0]                idx_q;
	logic [IDX_W-1:0]                cnt_q;
	logic [pswu_pkg::CHAN_W-1:0]     chan_q;
	logic                            pick_q;
	logic                            second_q;
	logic                            hit_q;
	logic [SLOT_COUNT-1:0]           mask_q;
	logic [pswu_pkg::COUNT_W-1:0]    woken_q;
	logic signed [pswu_pkg::PRIO_W-1:0] best_q;
	logic                            found_q;
	logic [IDX_W-1:0]                chosen_q;
	logic                            aborted_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	pswu_pkg::entry_t rd_entry;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	pswu_pkg::entry_t wr_entry;
	pswu_pkg::entry_t slot_new;
	pswu_pkg::entry_t woken_entry;

	logic             accept;
	logic             load_rsp;
	logic             slot_ok_in;
	logic             abort_in;
	logic [IDX_W-1:0] slot_idx_in;
	logic [IDX_W-1:0] slot_idx_q;
	logic [IDX_W-1:0] idx_next;
	logic [IDX_W-1:0] pick_start;
	logic             pass_last;
	logic             wake_match;
	logic             hit_now;
	logic             swap_in_wake;
	logic             pick_take;
	logic             found_d;
	logic [IDX_W-1:0] chosen_d;
	logic             second_pass;

	pswu_table #(
		.DEPTH  (SLOT_COUNT),
		.ADDR_W (IDX_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry)
	);

	assign slot_ok_in  = 32'(req.slot) < SLOT_COUNT;
	assign slot_idx_in = IDX_W'(req.slot);
	assign slot_idx_q  = IDX_W'(req_q.slot);
	assign abort_in    = (req.mode == pswu_pkg::MODE_SLEEP) && !req.priority_req[pswu_pkg::PRIO_W-1]
		&& req.signal_pending;
	assign idx_next    = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
	assign pick_start  = (last_q == LAST_IDX) ? '0 : last_q + IDX_W'(1);
	assign pass_last   = (cnt_q == LAST_IDX);
	assign accept      = req_valid && req_ready;

	// per-entry decisions during a table pass
	assign wake_match  = !pick_q && (rd_entry.status != pswu_pkg::STAT_EMPTY)
		&& (rd_entry.channel == chan_q);
	assign hit_now     = wake_match && swap_out_q && !rd_entry.loaded;
	assign pick_take   = pick_q && (rd_entry.status == pswu_pkg::STAT_RUNNABLE) && rd_entry.loaded
		&& (rd_entry.prio < best_q);
	assign found_d     = found_q || pick_take;
	assign chosen_d    = pick_take ? idx_q : chosen_q;
	assign second_pass = !pick_q && !second_q && (hit_q || hit_now);
	assign swap_in_wake = (req_q.mode == pswu_pkg::MODE_SLEEP)
		&& !req_q.priority_req[pswu_pkg::PRIO_W-1] && swap_in_q;

	always_comb begin
		woken_entry         = rd_entry;
		woken_entry.status  = pswu_pkg::STAT_RUNNABLE;
		woken_entry.channel = '0;
	end

	always_comb begin
		slot_new = rd_entry;
		case (req_q.mode)
			pswu_pkg::MODE_INSTALL: begin
				slot_new.status  = req_q.new_status;
				slot_new.loaded  = req_q.loaded_mark;
				slot_new.prio    = req_q.priority_req;
				slot_new.channel = req_q.channel;
			end
			pswu_pkg::MODE_SLEEP: begin
				slot_new.status  = req_q.priority_req[pswu_pkg::PRIO_W-1] ?
					pswu_pkg::STAT_SLEEPING : pswu_pkg::STAT_WAITING;
				slot_new.prio    = req_q.priority_req;
				slot_new.channel = req_q.channel;
			end
			pswu_pkg::MODE_SET_LOADED: begin
				slot_new.loaded = req_q.loaded_mark;
			end
			default: begin
				slot_new = rd_entry;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pswu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = idx_next;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_entry  = woken_entry;
		load_rsp  = 1'b0;
		case (state_q)
			pswu_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (req.mode)
						pswu_pkg::MODE_INSTALL, pswu_pkg::MODE_SLEEP,
						pswu_pkg::MODE_SET_LOADED: begin
							if (slot_ok_in && !abort_in) begin
								rd_en   = 1'b1;
								rd_addr = slot_idx_in;
								state_d = pswu_pkg::ST_SLOT;
							end else begin
								state_d = pswu_pkg::ST_EMIT;
							end
						end
						pswu_pkg::MODE_WAKE: begin
							rd_en   = 1'b1;
							rd_addr = '0;
							state_d = pswu_pkg::ST_SCAN;
						end
						pswu_pkg::MODE_PICK: begin
							rd_en   = 1'b1;
							rd_addr = pick_start;
							state_d = pswu_pkg::ST_SCAN;
						end
						default: begin
							state_d = pswu_pkg::ST_EMIT;
						end
					endcase
				end
			end
			pswu_pkg::ST_SLOT: begin
				wr_en    = 1'b1;
				wr_addr  = slot_idx_q;
				wr_entry = slot_new;
				state_d  = swap_in_wake ? pswu_pkg::ST_WAKE_START : pswu_pkg::ST_EMIT;
			end
			pswu_pkg::ST_WAKE_START: begin
				// read issued in the cycle after any slot write so it sees the new entry
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = pswu_pkg::ST_SCAN;
			end
			pswu_pkg::ST_SCAN: begin
				wr_en = wake_match;
				if (pass_last) begin
					state_d = second_pass ? pswu_pkg::ST_WAKE_START : pswu_pkg::ST_EMIT;
				end else begin
					rd_en = 1'b1;
				end
			end
			pswu_pkg::ST_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = pswu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pswu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_ceiling_q  <= pswu_pkg::PRIO_CEILING_RST;
			swap_in_chan_q  <= pswu_pkg::SWAP_IN_CHAN_RST;
			swap_out_chan_q <= pswu_pkg::SWAP_OUT_CHAN_RST;
			swap_in_q       <= 1'b0;
			swap_out_q      <= 1'b0;
			last_q          <= '0;
			req_q           <= '0;
			idx_q           <= '0;
			cnt_q           <= '0;
			chan_q          <= '0;
			pick_q          <= 1'b0;
			second_q        <= 1'b0;
			hit_q           <= 1'b0;
			mask_q          <= '0;
			woken_q         <= '0;
			best_q          <= '0;
			found_q         <= 1'b0;
			chosen_q        <= '0;
			aborted_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pswu_pkg::CFG_PRIO_CEILING:  prio_ceiling_q  <= cfg_wdata[pswu_pkg::CEIL_W-1:0];
					pswu_pkg::CFG_SWAP_IN_CHAN:  swap_in_chan_q  <= cfg_wdata;
					pswu_pkg::CFG_SWAP_OUT_CHAN: swap_out_chan_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				pswu_pkg::ST_IDLE: begin
					if (accept) begin
						req_q     <= req;
						mask_q    <= '0;
						woken_q   <= '0;
						hit_q     <= 1'b0;
						second_q  <= 1'b0;
						found_q   <= 1'b0;
						chosen_q  <= '0;
						best_q    <= $signed({1'b0, prio_ceiling_q});
						aborted_q <= abort_in && slot_ok_in;
						chan_q    <= req.channel;
						pick_q    <= (req.mode == pswu_pkg::MODE_PICK);
						idx_q     <= (req.mode == pswu_pkg::MODE_PICK) ? pick_start : '0;
						cnt_q     <= '0;
						if (req.mode == pswu_pkg::MODE_SET_FLAGS) begin
							swap_in_q  <= req.want_swap_in;
							swap_out_q <= req.want_swap_out;
						end
					end
				end
				pswu_pkg::ST_SLOT: begin
					if (swap_in_wake) begin
						swap_in_q <= 1'b0;
						chan_q    <= swap_in_chan_q;
					end
				end
				pswu_pkg::ST_WAKE_START: begin
					idx_q <= '0;
					cnt_q <= '0;
				end
				pswu_pkg::ST_SCAN: begin
					if (wake_match) begin
						mask_q[idx_q] <= 1'b1;
						// count each slot once even if the swap-out pass matches it again
						if (!mask_q[idx_q] && woken_q != COUNT_MAX) begin
							woken_q <= woken_q + pswu_pkg::COUNT_W'(1);
						end
					end
					if (hit_now) begin
						swap_out_q <= 1'b0;
						hit_q      <= 1'b1;
					end
					if (pick_take) begin
						best_q   <= rd_entry.prio;
						chosen_q <= idx_q;
						found_q  <= 1'b1;
					end
					if (pass_last) begin
						if (pick_q) begin
							last_q <= found_d ? chosen_d : '0;
						end
						if (second_pass) begin
							second_q <= 1'b1;
							chan_q   <= swap_out_chan_q;
						end
					end else begin
						idx_q <= idx_next;
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.chosen_slot   <= found_q ? pswu_pkg::SLOT_W'(chosen_q) : '0;
			rsp_q.chosen_valid  <= found_q;
			rsp_q.woken_count   <= woken_q;
			rsp_q.reschedule    <= (woken_q != '0);
			rsp_q.sleep_aborted <= aborted_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/pswu_checker.sv
// port-level assertions for the process sleep/wakeup scheduler, bound to the top level
module pswu_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input pswu_pkg::rsp_t rsp
);

	// a stalled result transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_resched: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.reschedule == (rsp.woken_count != '0))
		else $error("reschedule does not follow woken count");

	// a pick never wakes anything
	a_pick_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.chosen_valid |-> !rsp.sleep_aborted && rsp.woken_count == '0)
		else $error("pick result carries wake or abort");

	a_abort_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.sleep_aborted |-> !rsp.chosen_valid && rsp.woken_count == '0
			&& rsp.chosen_slot == '0)
		else $error("aborted sleep changed other results");

endmodule

bind process_sleep_wakeup_scheduler pswu_checker u_pswu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
